// File: sv/hhlp_pkg.sv
// ----------------------------------------------------------------------------
// hhlp_pkg
// Types and constants for the HTTP header line parser.
// ----------------------------------------------------------------------------
package hhlp_pkg;

  localparam int unsigned OFFSET_W = 10;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [OFFSET_W-1:0] MAX_VALUE_OFFSET_RST = 10'd255;

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_KEY    = 4'd1,
    ST_COLON  = 4'd2,
    ST_SPACE  = 4'd3,
    ST_VALUE  = 4'd4,
    ST_CR     = 4'd5,
    ST_LF     = 4'd6,
    ST_END_CR = 4'd7,
    ST_BODY   = 4'd8,
    ST_ERROR  = 4'd9
  } parse_state_t;

  typedef enum logic [1:0] {
    KIND_DELIM = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_VALUE = 2'd2,
    KIND_BODY  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_KEY_CRLF  = 3'd1,
    ERR_NO_SPACE  = 3'd2,
    ERR_NO_LF     = 3'd3,
    ERR_VALUE_LEN = 3'd4,
    ERR_STICKY    = 3'd5
  } err_cause_t;

endpackage

// File: sv/http_header_line_parser.sv
// ----------------------------------------------------------------------------
// http_header_line_parser
// Byte-wide HTTP header tokenizer: tags each byte, flags pair and header ends,
// reports malformed input with a sticky error.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload                         | handshake
//  ---------+-----------+---------------------------------+-----------------
//  s_axis   | in        | tdata: data_byte, tuser: restart | tvalid/tready
//  m_axis   | out       | tdata: byte_out, tuser: tags     | tvalid/tready
//  cfg      | in        | cfg_data: max_value_offset       | cfg_valid/ready
//
//  One item per cycle unless m_axis stalls; the parse state update and the
//  result register load happen at the same edge the item is accepted.
//  The result register frees up in the cycle it is taken, so s_axis_tready
//  only drops while a result sits unread and m_axis_tready is low.
//  Reset (rst, synchronous) puts the parser in the start state, clears the
//  value offset and loads max_value_offset with 255.
//  cfg_ready is always high; writes are expected only while the block is idle.
//
module http_header_line_parser
  import hhlp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // stream in
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]          s_axis_tuser,   // [0] restart
  // stream out
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] byte_out
  output logic [6:0]          m_axis_tuser,   // [1:0] kind, [2] pair_end,
                                              // [3] headers_end, [6:4] error_cause
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [OFFSET_W-1:0] cfg_data        // max_value_offset
);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  parse_state_t          state, state_next;
  logic [OFFSET_W-1:0]   value_offset, value_offset_next;
  logic [OFFSET_W-1:0]   max_value_offset;

  // result register
  logic                  out_valid;
  logic [7:0]            out_byte;
  kind_t                 out_kind;
  logic                  out_pair_end;
  logic                  out_headers_end;
  err_cause_t            out_cause;

  // per-item decode
  parse_state_t          cur_state;
  logic [OFFSET_W-1:0]   cur_offset;
  logic [OFFSET_W:0]     offset_inc;
  logic [7:0]            b;
  logic                  is_cr, is_lf;
  kind_t                 kind;
  logic                  pair_end, headers_end;
  err_cause_t            cause;
  logic                  in_fire;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign cfg_ready     = 1'b1;

  assign b     = s_axis_tdata;
  assign is_cr = (b == CH_CR);
  assign is_lf = (b == CH_LF);

  // restart takes effect before the byte is looked at
  assign cur_state  = s_axis_tuser[0] ? ST_START : state;
  assign cur_offset = s_axis_tuser[0] ? '0 : value_offset;
  assign offset_inc = {1'b0, cur_offset} + {{OFFSET_W{1'b0}}, 1'b1};

  // --------------------------------------------------------------------------
  // Next state and tags for the byte at the input
  // --------------------------------------------------------------------------
  always_comb begin
    state_next        = cur_state;
    value_offset_next = cur_offset;
    kind              = KIND_DELIM;
    pair_end          = 1'b0;
    headers_end       = 1'b0;
    cause             = ERR_NONE;

    unique case (cur_state)
      ST_START: begin
        // leading CR/LF are skipped
        if (!is_cr && !is_lf) begin
          kind       = KIND_KEY;
          state_next = ST_KEY;
        end
      end
      ST_KEY: begin
        if (b == CH_COLON) begin
          state_next = ST_COLON;
        end else if (is_cr || is_lf) begin
          cause = ERR_KEY_CRLF;
        end else begin
          kind = KIND_KEY;
        end
      end
      ST_COLON: begin
        if (b == CH_SPACE) begin
          state_next = ST_SPACE;
        end else begin
          cause = ERR_NO_SPACE;
        end
      end
      ST_SPACE: begin
        // first value byte, whatever it is
        kind              = KIND_VALUE;
        value_offset_next = '0;
        state_next        = ST_VALUE;
      end
      ST_VALUE: begin
        // only CR ends a value; LF is a value byte
        if (is_cr) begin
          state_next = ST_CR;
        end else if (offset_inc > {1'b0, max_value_offset}) begin
          cause = ERR_VALUE_LEN;
        end else begin
          value_offset_next = offset_inc[OFFSET_W-1:0];
          kind              = KIND_VALUE;
        end
      end
      ST_CR: begin
        if (is_lf) begin
          pair_end   = 1'b1;
          state_next = ST_LF;
        end else begin
          cause = ERR_NO_LF;
        end
      end
      ST_LF: begin
        if (is_cr) begin
          state_next = ST_END_CR;
        end else begin
          kind       = KIND_KEY;
          state_next = ST_KEY;
        end
      end
      ST_END_CR: begin
        if (is_lf) begin
          headers_end = 1'b1;
          state_next  = ST_BODY;
        end else begin
          cause = ERR_NO_LF;
        end
      end
      ST_BODY: begin
        kind = KIND_BODY;
      end
      default: begin
        // error state and unused codes
        cause = ERR_STICKY;
      end
    endcase

    // the byte that raises an error carries no tag
    if (cause != ERR_NONE) begin
      kind        = KIND_DELIM;
      pair_end    = 1'b0;
      headers_end = 1'b0;
      state_next  = ST_ERROR;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_START;
      value_offset <= '0;
    end else if (in_fire) begin
      state        <= state_next;
      value_offset <= value_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_value_offset <= MAX_VALUE_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_value_offset <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_byte        <= b;
      out_kind        <= kind;
      out_pair_end    <= pair_end;
      out_headers_end <= headers_end;
      out_cause       <= cause;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tuser  = {out_cause, out_headers_end, out_pair_end, out_kind};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // an error result carries no tag and leaves the parser in error
  a_err_untagged: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_cause != ERR_NONE) |->
      (out_kind == KIND_DELIM && !out_pair_end && !out_headers_end
       && state == ST_ERROR))
    else $error("error result with tag or parser not in error");

  // headers end only on LF, and the parser is then in the body
  a_hend_body: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_headers_end) |-> (out_byte == CH_LF && state == ST_BODY))
    else $error("headers_end without LF or body state");

  // pair end only on LF, and the parser then waits for a key or blank line
  a_pair_lf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pair_end) |-> (out_byte == CH_LF && state == ST_LF))
    else $error("pair_end without LF or line-start state");

  // a body byte only comes out of the body state
  a_body_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_BODY) |-> (state == ST_BODY))
    else $error("body byte outside body state");

  // the result register is not overwritten while it waits
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_axis_tready) |-> !in_fire)
    else $error("item accepted over an untaken result");
`endif

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for http_header_line_parser. A byte-level model tags
// each byte that is sent. Every result item is checked field by field against
// the oldest pending tag. Stimulus covers directed token and error cases,
// value length limits at several register settings, and random header
// sections, some of them corrupted. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb;
  import hhlp_pkg::*;

  // Result register is one deep; a few spare cycles cover it after a drain.
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_GAP       = 20;

  // Expected tagging of one byte, in result field order.
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       pair_end;
    logic       headers_end;
    err_cause_t cause;
  } byte_tag_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;   // [7:0] data_byte
  logic [0:0]          s_axis_tuser  = '0;   // [0] restart
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b1;
  logic [7:0]          m_axis_tdata;         // [7:0] byte_out
  logic [6:0]          m_axis_tuser;         // [1:0] kind, [2] pair_end,
                                             // [3] headers_end, [6:4] error_cause
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [OFFSET_W-1:0] cfg_data      = '0;   // max_value_offset

  // Parser model state and its copy of the register.
  parse_state_t        model_state  = ST_START;
  logic [OFFSET_W-1:0] model_offset = '0;
  logic [OFFSET_W-1:0] model_limit  = MAX_VALUE_OFFSET_RST;

  byte_tag_t  expected_tags[$];
  logic [8:0] hdr_bytes[$];      // {restart, data_byte}

  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int n_mismatch   = 0;

  http_header_line_parser u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Parser model: tags one byte and advances the model state.
  // ------------------------------------------------------------------------
  function automatic byte_tag_t tag_byte(input logic [7:0] b, input logic restart);
    byte_tag_t t;
    t = '{data: b, kind: KIND_DELIM, pair_end: 1'b0, headers_end: 1'b0,
          cause: ERR_NONE};
    if (restart) begin
      model_state  = ST_START;
      model_offset = '0;
    end
    case (model_state)
      ST_START: begin
        // leading CR/LF are skipped
        if (b != CH_CR && b != CH_LF) begin
          t.kind      = KIND_KEY;
          model_state = ST_KEY;
        end
      end
      ST_KEY: begin
        if (b == CH_COLON) model_state = ST_COLON;
        else if (b == CH_CR || b == CH_LF) t.cause = ERR_KEY_CRLF;
        else t.kind = KIND_KEY;
      end
      ST_COLON: begin
        if (b == CH_SPACE) model_state = ST_SPACE;
        else t.cause = ERR_NO_SPACE;
      end
      ST_SPACE: begin
        // first value byte is taken as is, even CR or LF
        t.kind       = KIND_VALUE;
        model_offset = '0;
        model_state  = ST_VALUE;
      end
      ST_VALUE: begin
        // only CR ends a value; LF is a plain value byte
        if (b == CH_CR) begin
          model_state = ST_CR;
        end else if ({1'b0, model_offset} + 11'd1 > {1'b0, model_limit}) begin
          t.cause = ERR_VALUE_LEN;
        end else begin
          model_offset = model_offset + 1'b1;
          t.kind       = KIND_VALUE;
        end
      end
      ST_CR: begin
        if (b == CH_LF) begin
          t.pair_end  = 1'b1;
          model_state = ST_LF;
        end else begin
          t.cause = ERR_NO_LF;
        end
      end
      ST_LF: begin
        if (b == CH_CR) begin
          model_state = ST_END_CR;
        end else begin
          t.kind      = KIND_KEY;
          model_state = ST_KEY;
        end
      end
      ST_END_CR: begin
        if (b == CH_LF) begin
          t.headers_end = 1'b1;
          model_state   = ST_BODY;
        end else begin
          t.cause = ERR_NO_LF;
        end
      end
      ST_BODY: t.kind = KIND_BODY;
      default: t.cause = ERR_STICKY;
    endcase
    // the byte that raises an error carries no tag and no flag
    if (t.cause != ERR_NONE) begin
      t.kind        = KIND_DELIM;
      t.pair_end    = 1'b0;
      t.headers_end = 1'b0;
      model_state   = ST_ERROR;
    end
    return t;
  endfunction

  function automatic logic [7:0] rand_key_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_CR || b == CH_LF || b == CH_COLON);
    return b;
  endfunction

  function automatic logic [7:0] rand_value_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_CR);
    return b;
  endfunction

  // Fills hdr_bytes with one header section: mostly well formed with random
  // content, sometimes corrupted, sometimes pure noise.
  function automatic void build_header_section();
    int         len;
    int         idx;
    logic [7:0] b;
    hdr_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8))
        hdr_bytes.push_back({1'($urandom_range(0, 7) == 0), 8'($urandom)});
      return;
    end
    repeat ($urandom_range(0, 2))
      hdr_bytes.push_back({1'b0, ($urandom_range(0, 1) != 0) ? CH_CR : CH_LF});
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 5)) hdr_bytes.push_back({1'b0, rand_key_byte()});
      hdr_bytes.push_back({1'b0, CH_COLON});
      hdr_bytes.push_back({1'b0, CH_SPACE});
      // now and then a value near the length limit: just under it, right at it or one past it
      if (model_limit < 64 && $urandom_range(0, 4) == 0)
        len = int'(model_limit) + $urandom_range(0, 2);
      else
        len = $urandom_range(1, 6);
      hdr_bytes.push_back({1'b0, 8'($urandom)});
      repeat (len - 1) hdr_bytes.push_back({1'b0, rand_value_byte()});
      hdr_bytes.push_back({1'b0, CH_CR});
      hdr_bytes.push_back({1'b0, CH_LF});
    end
    hdr_bytes.push_back({1'b0, CH_CR});
    hdr_bytes.push_back({1'b0, CH_LF});
    repeat ($urandom_range(0, 3)) hdr_bytes.push_back({1'b0, 8'($urandom)});
    // mostly a fresh start; otherwise carry on from the state the last section left
    hdr_bytes[0][8] = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 3) == 0) begin
      idx = $urandom_range(0, hdr_bytes.size() - 1);
      case ($urandom_range(0, 4))
        0:       b = CH_CR;
        1:       b = CH_LF;
        2:       b = CH_COLON;
        3:       b = CH_SPACE;
        default: b = 8'($urandom);
      endcase
      hdr_bytes[idx][7:0] = b;
    end
    if ($urandom_range(0, 19) == 0)
      hdr_bytes[$urandom_range(0, hdr_bytes.size() - 1)][8] = 1'b1;
  endfunction

  // ------------------------------------------------------------------------
  // Stream driver. Entered and left at a falling edge; tvalid stays high
  // between back-to-back items.
  // ------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic restart);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= restart;
    do @(posedge clk); while (!s_axis_tready);
    expected_tags.push_back(tag_byte(b, restart));
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic restart_first);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], restart_first && i == 0);
  endtask

  // Fresh "K: " line followed by n value bytes and no CR.
  task automatic send_long_value(input int n);
    send_text("K: ", 1'b1);
    repeat (n) send_byte(rand_value_byte(), 1'b0);
  endtask

  // Stop sending and let every pending result come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_tags.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_value_limit(input logic [OFFSET_W-1:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    model_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Token kinds, both flags, body bytes, data extremes and each early error.
  // CR is written as octal 015 in the strings below.
  task automatic test_directed_tokens();
    // leading CR/LF skipped, then key bytes incl. 0xFF
    send_text("\015\nK", 1'b1);
    send_byte(8'hFF, 1'b0);
    // CR as first value byte, LF inside the value, pair end, headers end
    send_text(": \015\n\015\n\015\n", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // LF inside a key, then one sticky byte
    send_text("K\nz", 1'b1);
    // no space after the colon
    send_text("K:x", 1'b1);
    // CR not followed by LF
    send_text("K: a\015x", 1'b1);
  endtask

  // Value length at the reset limit, at a limit of 1 and at the register top. Each
  // run has one byte past the limit so the last allowed offset is hit too.
  task automatic test_value_limit();
    send_long_value(int'(MAX_VALUE_OFFSET_RST) + 2);
    write_value_limit(10'd1);
    send_long_value(3);
    write_value_limit(10'd1023);
    send_long_value(1025);
  endtask

  task automatic test_random_headers(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      build_header_section();
      foreach (hdr_bytes[i]) send_byte(hdr_bytes[i][7:0], hdr_bytes[i][8]);
      sent += hdr_bytes.size();
    end
  endtask

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_mismatch++;
  endtask

  always @(negedge clk) m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);

  always @(posedge clk) begin : check_result
    byte_tag_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_tags.size() == 0) begin
        report_mismatch($sformatf("item %02h with no byte pending", m_axis_tdata));
      end else begin
        want = expected_tags.pop_front();
        if (m_axis_tdata !== want.data)
          report_mismatch($sformatf("byte_out %02h, want %02h", m_axis_tdata, want.data));
        if (m_axis_tuser[1:0] !== want.kind)
          report_mismatch($sformatf("byte %02h kind %0d, want %0d",
                                    want.data, m_axis_tuser[1:0], want.kind));
        if (m_axis_tuser[2] !== want.pair_end)
          report_mismatch($sformatf("byte %02h pair_end %b, want %b",
                                    want.data, m_axis_tuser[2], want.pair_end));
        if (m_axis_tuser[3] !== want.headers_end)
          report_mismatch($sformatf("byte %02h headers_end %b, want %b",
                                    want.data, m_axis_tuser[3], want.headers_end));
        if (m_axis_tuser[6:4] !== want.cause)
          report_mismatch($sformatf("byte %02h error_cause %0d, want %0d",
                                    want.data, m_axis_tuser[6:4], want.cause));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // sender idles less than the receiver
    snd_idle_pct = 30;
    rcv_idle_pct = 45;
    test_directed_tokens();
    test_value_limit();
    write_value_limit(10'($urandom_range(1, 24)));
    test_random_headers(30);

    // receiver idles less than the sender
    snd_idle_pct = 45;
    rcv_idle_pct = 30;
    write_value_limit(10'($urandom_range(1, 24)));
    test_random_headers(30);

    // full rate both ways
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_value_limit(10'($urandom_range(1, 1023)));
    test_random_headers(30);

    wait_drained();
    if (n_mismatch == 0) begin
      $display("http_header_line_parser test passed");
    end else begin
      $display("http_header_line_parser test failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("http_header_line_parser test failed");
    $finish;
  end

endmodule
